[hdl/dfsmc_pkg.sv]
// package for the depth-first maze carver
// holds sizes, status codes and the transfer payload types; no dependencies
`default_nettype none

package dfsmc_pkg;

    localparam int MAX_SIDE      = 64;
    localparam int STACK_DEPTH   = 1024;
    localparam int ROW_BITS      = $clog2(MAX_SIDE);
    localparam int MAP_IDX_BITS  = 2 * ROW_BITS;
    localparam int MAP_CELLS     = MAX_SIDE * MAX_SIDE;
    localparam int SP_BITS       = $clog2(STACK_DEPTH) + 1;
    localparam int SIDE_BITS     = 7;
    localparam int CMD_START     = 0;

    localparam logic [2:0] ST_STARTED  = 3'd0;
    localparam logic [2:0] ST_CARVED   = 3'd1;
    localparam logic [2:0] ST_BACKED   = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_BAD      = 3'd4;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [5:0] start_x;
        logic [5:0] start_y;
        logic [1:0] random_pick;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] new_cell;
        logic [11:0] between_cell;
        logic [5:0]  cur_x;
        logic [5:0]  cur_y;
        logic [10:0] stack_depth;
    } out_item_t;

endpackage

`default_nettype wire

[hdl/dfs_maze_carver.sv]
// Depth-first maze carver with a backtracking stack. A start transfer (cmd 0)
// checks the start cell. A step transfer (cmd 1) reads the eight neighbor
// tiles of the visited map, two per cycle from one 64-bit-row memory, then
// marks the carved tiles with read-modify-write. A backtrack splits the popped
// tile index into column and row with a radix-2 divider; a finish, an idle
// step or a bad start goes straight to the result.
// One item is in work at a time; the next one is taken while the last result
// waits on the output.
// The visited map is cleared at start by per-row valid flip-flops, so no
// clearing pass is needed. The stack holds 1024 entries; pushes beyond that
// are dropped.
// depends on dfsmc_pkg
`default_nettype none

module dfs_maze_carver
    import dfsmc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data,
    input  wire logic             cfg_we,
    input  wire logic             cfg_idx,
    input  wire logic [SIDE_BITS-1:0] cfg_wdata
);

    localparam int C_BITS  = 18;
    localparam int Y_BITS  = 11;
    localparam int SE_BITS = 13;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_MRD   = 4'd5;
    localparam logic [3:0] S_WR1   = 4'd6;
    localparam logic [3:0] S_WR2   = 4'd7;
    localparam logic [3:0] S_POP   = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    // storage
    logic [MAX_SIDE-1:0] vis_mem [MAP_CELLS/MAX_SIDE];
    logic [SE_BITS-1:0]  stk_mem [STACK_DEPTH];

    logic [3:0]              state_reg, state_next;
    logic [SIDE_BITS-1:0]    gw_reg, gh_reg;
    logic [MAX_SIDE-1:0]     rv_reg, rv_next;
    logic [SP_BITS-1:0]      sp_reg, sp_next;
    logic [5:0]              hx_reg, hx_next;
    logic [Y_BITS-1:0]       hy_reg, hy_next;
    logic                    act_reg, act_next;
    logic                    outv_reg, outv_next;
    out_item_t               out_reg, out_next;
    logic [2:0]              rst_reg, rst_next;
    logic [11:0]             rnew_reg, rnew_next;
    logic [11:0]             rbet_reg, rbet_next;
    logic [1:0]              pick_reg, pick_next;
    logic [C_BITS-1:0]       c_reg, c_next;
    logic [2:0]              ph_reg, ph_next;
    logic [7:0]              seen_reg, seen_next;
    logic [ROW_BITS-1:0]     ma_row_reg, ma_row_next, mb_row_reg, mb_row_next;
    logic [ROW_BITS-1:0]     ma_col_reg, ma_col_next, mb_col_reg, mb_col_next;
    logic                    ma_oob_reg, ma_oob_next, mb_oob_reg, mb_oob_next;
    logic [11:0]             nxt_reg, nxt_next, mid_reg, mid_next;
    logic [5:0]              nx_reg, nx_next;
    logic [Y_BITS-1:0]       ny_reg, ny_next;
    logic                    rva_reg, rva_next, rvb_reg, rvb_next;
    logic [SE_BITS-1:0]      dq_reg, dq_next;
    logic [5:0]              dr_reg, dr_next;
    logic [3:0]              dc_reg, dc_next;

    logic [MAX_SIDE-1:0]     rd_a_reg, rd_b_reg;
    logic [SE_BITS-1:0]      stk_rd_reg;

    logic [ROW_BITS-1:0]     addr_a, addr_b;
    logic                    mem_we;
    logic [ROW_BITS-1:0]     mem_waddr;
    logic [MAX_SIDE-1:0]     mem_wdata;
    logic                    push_en, pop_en;
    logic [SP_BITS-2:0]      push_addr, pop_addr;
    logic [SE_BITS-1:0]      push_data;

    logic [SIDE_BITS-1:0]    w, h;
    logic [C_BITS-1:0]       wx, idx_a, idx_b;
    logic                    start_ok;
    logic [3:0]              avail;
    logic [2:0]              n_avail;
    logic [1:0]              k_sel, d_sel, cnt;
    logic [6:0]              dsh;
    logic                    dbit;
    logic [MAX_SIDE-1:0]     bit_a, bit_b;

    function automatic logic [SIDE_BITS-1:0] clamp_side(input logic [SIDE_BITS-1:0] v);
        logic [SIDE_BITS-1:0] r;
        r = v;
        if (v < SIDE_BITS'(3))
            r = SIDE_BITS'(3);
        else if (v > SIDE_BITS'(MAX_SIDE))
            r = SIDE_BITS'(MAX_SIDE);
        return r;
    endfunction

    function automatic logic [MAX_SIDE-1:0] onehot(input logic [ROW_BITS-1:0] col);
        logic [MAX_SIDE-1:0] r;
        r = '0;
        r[col] = 1'b1;
        return r;
    endfunction

    assign w  = clamp_side(gw_reg);
    assign h  = clamp_side(gh_reg);
    assign wx = C_BITS'(w);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = outv_reg;
    assign out_data  = out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= SIDE_BITS'(63);
            gh_reg <= SIDE_BITS'(63);
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_WIDTH)
                gw_reg <= cfg_wdata;
            else
                gh_reg <= cfg_wdata;
        end
    end

    // neighbor tile pair read in each phase
    always_comb
    begin
        case (ph_reg[1:0])
            2'd0:
            begin
                idx_a = c_reg - C_BITS'(2);
                idx_b = c_reg - C_BITS'(1);
            end
            2'd1:
            begin
                idx_a = c_reg + C_BITS'(2);
                idx_b = c_reg + C_BITS'(1);
            end
            2'd2:
            begin
                idx_a = c_reg - (wx << 1);
                idx_b = c_reg - wx;
            end
            default:
            begin
                idx_a = c_reg + (wx << 1);
                idx_b = c_reg + wx;
            end
        endcase
    end

    // direction choice
    always_comb
    begin
        avail[0] = (hx_reg > 6'd2) && !seen_reg[0] && !seen_reg[1];
        avail[1] = ((7'(hx_reg) + 7'd2) < w) && !seen_reg[2] && !seen_reg[3];
        avail[2] = (hy_reg > Y_BITS'(2)) && !seen_reg[4] && !seen_reg[5];
        avail[3] = ((12'(hy_reg) + 12'd2) < 12'(h)) && !seen_reg[6] && !seen_reg[7];
        n_avail  = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
        case (n_avail)
            3'd2:    k_sel = {1'b0, pick_reg[0]};
            3'd3:    k_sel = (pick_reg == 2'd3) ? 2'd0 : pick_reg;
            3'd4:    k_sel = pick_reg;
            default: k_sel = 2'd0;
        endcase
        d_sel = 2'd0;
        cnt   = 2'd0;
        for (int d = 0; d < 4; d++)
        begin
            if (avail[d] && cnt == k_sel)
                d_sel = 2'(d);
            if (avail[d])
                cnt = cnt + 2'd1;
        end
    end

    assign dsh  = {dr_reg, dq_reg[SE_BITS-1]};
    assign dbit = (dsh >= w);

    assign bit_a = onehot(mid_reg[ROW_BITS-1:0]);
    assign bit_b = onehot(nxt_reg[ROW_BITS-1:0]);

    always_comb
    begin
        state_next  = state_reg;
        rv_next     = rv_reg;
        sp_next     = sp_reg;
        hx_next     = hx_reg;
        hy_next     = hy_reg;
        act_next    = act_reg;
        outv_next   = outv_reg;
        out_next    = out_reg;
        rst_next    = rst_reg;
        rnew_next   = rnew_reg;
        rbet_next   = rbet_reg;
        pick_next   = pick_reg;
        c_next      = c_reg;
        ph_next     = ph_reg;
        seen_next   = seen_reg;
        ma_row_next = ma_row_reg;
        mb_row_next = mb_row_reg;
        ma_col_next = ma_col_reg;
        mb_col_next = mb_col_reg;
        ma_oob_next = ma_oob_reg;
        mb_oob_next = mb_oob_reg;
        nxt_next    = nxt_reg;
        mid_next    = mid_reg;
        nx_next     = nx_reg;
        ny_next     = ny_reg;
        rva_next    = rva_reg;
        rvb_next    = rvb_reg;
        dq_next     = dq_reg;
        dr_next     = dr_reg;
        dc_next     = dc_reg;
        addr_a      = ma_row_reg;
        addr_b      = mb_row_reg;
        mem_we      = 1'b0;
        mem_waddr   = mid_reg[MAP_IDX_BITS-1:ROW_BITS];
        mem_wdata   = '0;
        push_en     = 1'b0;
        pop_en      = 1'b0;
        push_addr   = sp_reg[SP_BITS-2:0];
        pop_addr    = SP_BITS'(sp_reg - SP_BITS'(1)) >> 0 == '0 ? '0 :
                      sp_reg[SP_BITS-2:0] - (SP_BITS-1)'(1);
        push_data   = c_reg[SE_BITS-1:0];
        start_ok    = in_data.start_x[0] && in_data.start_y[0] &&
                      (7'(in_data.start_x) < w) && (7'(in_data.start_y) < h);

        if (outv_reg && out_ready)
            outv_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pick_next = in_data.random_pick;
                    rnew_next = '0;
                    rbet_next = '0;
                    rst_next  = ST_FINISHED;
                    state_next = S_DONE;
                    if (in_data.cmd == 1'(CMD_START))
                    begin
                        rv_next = '0;
                        sp_next = '0;
                        if (start_ok)
                        begin
                            c_next   = C_BITS'(in_data.start_y) * wx
                                       + C_BITS'(in_data.start_x);
                            hx_next  = in_data.start_x;
                            hy_next  = Y_BITS'(in_data.start_y);
                            act_next = 1'b1;
                            state_next = S_START;
                        end
                        else
                        begin
                            act_next = 1'b0;
                            rst_next = ST_BAD;
                        end
                    end
                    else if (act_reg)
                    begin
                        if (sp_reg == '0)
                            act_next = 1'b0;
                        else
                            state_next = S_CALC;
                    end
                end
            end

            S_START:
            begin
                mem_we    = 1'b1;
                mem_waddr = c_reg[MAP_IDX_BITS-1:ROW_BITS];
                mem_wdata = onehot(c_reg[ROW_BITS-1:0]);
                rv_next[c_reg[MAP_IDX_BITS-1:ROW_BITS]] = 1'b1;
                push_en   = 1'b1;
                push_addr = '0;
                sp_next   = SP_BITS'(1);
                rst_next  = ST_STARTED;
                rnew_next = c_reg[11:0];
                state_next = S_DONE;
            end

            S_CALC:
            begin
                c_next  = C_BITS'(hy_reg) * wx + C_BITS'(hx_reg);
                ph_next = '0;
                state_next = S_READ;
            end

            S_READ:
            begin
                // capture the pair issued in the last phase
                if (ph_reg != '0)
                begin
                    seen_next[2*(ph_reg-3'd1)]   = ma_oob_reg ||
                        (rv_reg[ma_row_reg] && rd_a_reg[ma_col_reg]);
                    seen_next[2*(ph_reg-3'd1)+1] = mb_oob_reg ||
                        (rv_reg[mb_row_reg] && rd_b_reg[mb_col_reg]);
                end
                if (ph_reg[2])
                    state_next = S_EVAL;
                else
                begin
                    addr_a      = idx_a[MAP_IDX_BITS-1:ROW_BITS];
                    addr_b      = idx_b[MAP_IDX_BITS-1:ROW_BITS];
                    ma_row_next = idx_a[MAP_IDX_BITS-1:ROW_BITS];
                    mb_row_next = idx_b[MAP_IDX_BITS-1:ROW_BITS];
                    ma_col_next = idx_a[ROW_BITS-1:0];
                    mb_col_next = idx_b[ROW_BITS-1:0];
                    ma_oob_next = (idx_a[C_BITS-1:MAP_IDX_BITS] != '0);
                    mb_oob_next = (idx_b[C_BITS-1:MAP_IDX_BITS] != '0);
                end
                ph_next = ph_reg + 3'd1;
            end

            S_EVAL:
            begin
                if (n_avail != '0)
                begin
                    nx_next = hx_reg;
                    ny_next = hy_reg;
                    case (d_sel)
                        2'd0:
                        begin
                            nxt_next = 12'(c_reg - C_BITS'(2));
                            mid_next = 12'(c_reg - C_BITS'(1));
                            nx_next  = hx_reg - 6'd2;
                        end
                        2'd1:
                        begin
                            nxt_next = 12'(c_reg + C_BITS'(2));
                            mid_next = 12'(c_reg + C_BITS'(1));
                            nx_next  = hx_reg + 6'd2;
                        end
                        2'd2:
                        begin
                            nxt_next = 12'(c_reg - (wx << 1));
                            mid_next = 12'(c_reg - wx);
                            ny_next  = hy_reg - Y_BITS'(2);
                        end
                        default:
                        begin
                            nxt_next = 12'(c_reg + (wx << 1));
                            mid_next = 12'(c_reg + wx);
                            ny_next  = hy_reg + Y_BITS'(2);
                        end
                    endcase
                    if (sp_reg < SP_BITS'(STACK_DEPTH))
                    begin
                        push_en = 1'b1;
                        sp_next = sp_reg + SP_BITS'(1);
                    end
                    state_next = S_MRD;
                end
                else
                begin
                    pop_en   = 1'b1;
                    pop_addr = SP_BITS'(sp_reg - SP_BITS'(1)) >> 0 == '0 ? '0 :
                               sp_reg[SP_BITS-2:0] - (SP_BITS-1)'(1);
                    sp_next  = sp_reg - SP_BITS'(1);
                    state_next = S_POP;
                end
            end

            S_MRD:
            begin
                addr_a   = mid_reg[MAP_IDX_BITS-1:ROW_BITS];
                addr_b   = nxt_reg[MAP_IDX_BITS-1:ROW_BITS];
                rva_next = rv_reg[mid_reg[MAP_IDX_BITS-1:ROW_BITS]];
                rvb_next = rv_reg[nxt_reg[MAP_IDX_BITS-1:ROW_BITS]];
                state_next = S_WR1;
            end

            S_WR1:
            begin
                // keep the carve rows addressed so the second write sees its row
                addr_a    = mid_reg[MAP_IDX_BITS-1:ROW_BITS];
                addr_b    = nxt_reg[MAP_IDX_BITS-1:ROW_BITS];
                // same row: both marks go into each write
                mem_we    = 1'b1;
                mem_waddr = mid_reg[MAP_IDX_BITS-1:ROW_BITS];
                mem_wdata = (rva_reg ? rd_a_reg : '0) | bit_a |
                            ((mid_reg[MAP_IDX_BITS-1:ROW_BITS] ==
                              nxt_reg[MAP_IDX_BITS-1:ROW_BITS]) ? bit_b : '0);
                rv_next[mid_reg[MAP_IDX_BITS-1:ROW_BITS]] = 1'b1;
                state_next = S_WR2;
            end

            S_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = nxt_reg[MAP_IDX_BITS-1:ROW_BITS];
                mem_wdata = (rvb_reg ? rd_b_reg : '0) | bit_b |
                            ((mid_reg[MAP_IDX_BITS-1:ROW_BITS] ==
                              nxt_reg[MAP_IDX_BITS-1:ROW_BITS]) ? bit_a : '0);
                rv_next[nxt_reg[MAP_IDX_BITS-1:ROW_BITS]] = 1'b1;
                hx_next   = nx_reg;
                hy_next   = ny_reg;
                rst_next  = ST_CARVED;
                rnew_next = nxt_reg;
                rbet_next = mid_reg;
                state_next = S_DONE;
            end

            S_POP:
            begin
                dq_next = stk_rd_reg;
                dr_next = '0;
                dc_next = 4'(SE_BITS);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                dr_next = dbit ? 6'(dsh - w) : dsh[5:0];
                dq_next = {dq_reg[SE_BITS-2:0], dbit};
                dc_next = dc_reg - 4'd1;
                if (dc_reg == 4'd1)
                begin
                    hx_next  = dbit ? 6'(dsh - w) : dsh[5:0];
                    hy_next  = Y_BITS'({dq_reg[SE_BITS-2:0], dbit});
                    rst_next = ST_BACKED;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!outv_reg || out_ready)
                begin
                    outv_next             = 1'b1;
                    out_next.status       = rst_reg;
                    out_next.new_cell     = rnew_reg;
                    out_next.between_cell = rbet_reg;
                    out_next.cur_x        = hx_reg;
                    out_next.cur_y        = hy_reg[5:0];
                    out_next.stack_depth  = sp_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= '0;
            sp_reg    <= '0;
            hx_reg    <= '0;
            hy_reg    <= '0;
            act_reg   <= 1'b0;
            outv_reg  <= 1'b0;
            ph_reg    <= '0;
            dc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            sp_reg    <= sp_next;
            hx_reg    <= hx_next;
            hy_reg    <= hy_next;
            act_reg   <= act_next;
            outv_reg  <= outv_next;
            ph_reg    <= ph_next;
            dc_reg    <= dc_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        rst_reg    <= rst_next;
        rnew_reg   <= rnew_next;
        rbet_reg   <= rbet_next;
        pick_reg   <= pick_next;
        c_reg      <= c_next;
        seen_reg   <= seen_next;
        ma_row_reg <= ma_row_next;
        mb_row_reg <= mb_row_next;
        ma_col_reg <= ma_col_next;
        mb_col_reg <= mb_col_next;
        ma_oob_reg <= ma_oob_next;
        mb_oob_reg <= mb_oob_next;
        nxt_reg    <= nxt_next;
        mid_reg    <= mid_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        rva_reg    <= rva_next;
        rvb_reg    <= rvb_next;
        dq_reg     <= dq_next;
        dr_reg     <= dr_next;
    end

    // visited map, one row of tiles per word
    always_ff @(posedge clk)
    begin
        if (mem_we)
            vis_mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= vis_mem[addr_a];
        rd_b_reg <= vis_mem[addr_b];
    end

    // backtrack stack
    always_ff @(posedge clk)
    begin
        if (push_en)
            stk_mem[push_addr] <= push_data;
        if (pop_en)
            stk_rd_reg <= stk_mem[pop_addr];
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_BITS'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_carve_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (outv_reg && out_reg.status == ST_CARVED) |-> out_reg.stack_depth != '0)
        else $error("carve reported with an empty stack");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (7'(dr_reg) < w))
        else $error("divider remainder not below width");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && n_avail == '0) |-> sp_reg != '0)
        else $error("pop from an empty stack");

endmodule

`default_nettype wire

[test/dfs_maze_carver_checker.sv]
// checker for the depth-first maze carver: watches both channels and the
// config port, predicts each result and compares it; depends on dfsmc_pkg
`timescale 1ns / 1ps

module dfs_maze_carver_checker
    import dfsmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_item_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_idx,
    input  logic [SIDE_BITS-1:0] cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    logic                     seen_map [MAP_CELLS];
    logic [11:0]              trail [STACK_DEPTH];
    int unsigned              trail_len;
    int unsigned              pos_x;
    int unsigned              pos_y;
    logic                     walking;
    logic [SIDE_BITS-1:0]     side_w;
    logic [SIDE_BITS-1:0]     side_h;
    out_item_t                expected_steps [$];

    function automatic int unsigned clamp_side(logic [SIDE_BITS-1:0] v);
        if (v < 3)
            return 3;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    function automatic logic is_seen(int unsigned idx);
        if (idx >= MAP_CELLS)
            return 1'b1;
        return seen_map[idx];
    endfunction

    function automatic void mark_tile(int unsigned idx);
        if (idx < MAP_CELLS)
            seen_map[idx] = 1'b1;
    endfunction

    function automatic out_item_t carve_step(in_item_t it);
        int unsigned w, h, c, n, k, top, x, y;
        int unsigned nxt [4];
        int unsigned mid [4];
        int unsigned nx [4];
        int unsigned ny [4];
        out_item_t r;
        w = clamp_side(side_w);
        h = clamp_side(side_h);
        r = '0;
        r.status = ST_FINISHED;
        n = 0;
        if (it.cmd == 1'(CMD_START)) begin
            foreach (seen_map[i])
                seen_map[i] = 1'b0;
            trail_len = 0;
            if (it.start_x[0] && it.start_y[0] && it.start_x < w && it.start_y < h)
            begin
                c = it.start_y * w + it.start_x;
                mark_tile(c);
                trail[0] = 12'(c);
                trail_len = 1;
                pos_x = it.start_x;
                pos_y = it.start_y;
                walking = 1'b1;
                r.status = ST_STARTED;
                r.new_cell = 12'(c);
            end
            else
            begin
                walking = 1'b0;
                r.status = ST_BAD;
            end
        end
        else if (walking)
        begin
            if (trail_len == 0)
            begin
                walking = 1'b0;
            end
            else
            begin
                x = pos_x;
                y = pos_y;
                c = y * w + x;
                if (x > 2 && !is_seen(c - 2) && !is_seen(c - 1))
                begin
                    nxt[n] = c - 2; mid[n] = c - 1; nx[n] = x - 2; ny[n] = y; n++;
                end
                if (x + 2 < w && !is_seen(c + 2) && !is_seen(c + 1))
                begin
                    nxt[n] = c + 2; mid[n] = c + 1; nx[n] = x + 2; ny[n] = y; n++;
                end
                if (y > 2 && !is_seen(c - 2 * w) && !is_seen(c - w))
                begin
                    nxt[n] = c - 2 * w; mid[n] = c - w; nx[n] = x; ny[n] = y - 2; n++;
                end
                if (y + 2 < h && !is_seen(c + 2 * w) && !is_seen(c + w))
                begin
                    nxt[n] = c + 2 * w; mid[n] = c + w; nx[n] = x; ny[n] = y + 2; n++;
                end
                if (n > 0)
                begin
                    k = it.random_pick % n;
                    mark_tile(nxt[k]);
                    mark_tile(mid[k]);
                    if (trail_len < STACK_DEPTH)
                    begin
                        trail[trail_len] = 12'(c);
                        trail_len++;
                    end
                    pos_x = nx[k];
                    pos_y = ny[k];
                    r.status = ST_CARVED;
                    r.new_cell = 12'(nxt[k]);
                    r.between_cell = 12'(mid[k]);
                end
                else
                begin
                    trail_len--;
                    top = trail[trail_len];
                    pos_x = top % w;
                    pos_y = top / w;
                    r.status = ST_BACKED;
                end
            end
        end
        r.cur_x = 6'(pos_x);
        r.cur_y = 6'(pos_y);
        r.stack_depth = 11'(trail_len);
        return r;
    endfunction

    assign pending = expected_steps.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            foreach (seen_map[i])
                seen_map[i] = 1'b0;
            trail_len = 0;
            pos_x = 0;
            pos_y = 0;
            walking = 1'b0;
            side_w = 63;
            side_h = 63;
            expected_steps.delete();
            fail_count = 0;
        end
        else
        begin
            // the result transfer is checked before this edge's input is predicted
            if (out_valid && out_ready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("unexpected result transfer %p", out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_steps.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.new_cell !== want.new_cell)
                    begin
                        $error("new_cell expected %0d got %0d", want.new_cell,
                            out_data.new_cell);
                        fail_count++;
                    end
                    if (out_data.between_cell !== want.between_cell)
                    begin
                        $error("between_cell expected %0d got %0d", want.between_cell,
                            out_data.between_cell);
                        fail_count++;
                    end
                    if (out_data.cur_x !== want.cur_x)
                    begin
                        $error("cur_x expected %0d got %0d", want.cur_x, out_data.cur_x);
                        fail_count++;
                    end
                    if (out_data.cur_y !== want.cur_y)
                    begin
                        $error("cur_y expected %0d got %0d", want.cur_y, out_data.cur_y);
                        fail_count++;
                    end
                    if (out_data.stack_depth !== want.stack_depth)
                    begin
                        $error("stack_depth expected %0d got %0d", want.stack_depth,
                            out_data.stack_depth);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_idx == REG_WIDTH)
                    side_w = cfg_wdata;
                else
                    side_h = cfg_wdata;
            end
            if (in_valid && in_ready)
            begin
                want = carve_step(in_data);
                expected_steps.insert(expected_steps.size(), want);
            end
        end
    end

endmodule

[test/dfs_maze_carver_tb.sv]
// top of the maze carver testbench: clock, reset, stimulus and verdict
// depends on dfsmc_pkg, dfs_maze_carver and dfs_maze_carver_checker
`timescale 1ns / 1ps

module dfs_maze_carver_tb;
    import dfsmc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_we;
    logic                 cfg_idx;
    logic [SIDE_BITS-1:0] cfg_wdata;
    int                   fail_count;
    int                   pending;
    logic                 calm;
    int                   out_hold;

    dfs_maze_carver dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    dfs_maze_carver_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver stalls in random bursts; when calm it is always ready
    initial
    begin
        out_ready = 1'b0;
        out_hold = 0;
        forever
        begin
            @(negedge clk);
            if (calm)
                out_ready <= 1'b1;
            else if (out_hold > 0)
            begin
                out_hold--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                out_hold = $urandom_range(0, 3);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(logic cmd, logic [5:0] sx, logic [5:0] sy, logic [1:0] pick);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge clk);
        end
        in_data <= '{cmd: cmd, start_x: sx, start_y: sy, random_pick: pick};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        // the block is busy in this cycle anyway, so the next item loses nothing
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        // once every result is out the block is idle; the extra wait only adds slack
        repeat (40) @(negedge clk);
    endtask

    task automatic set_side(logic idx, logic [SIDE_BITS-1:0] v);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // a start at a random odd cell inside the grid, then a walk of steps with an occasional random item
    task automatic run_walk(int unsigned w, int unsigned h, int steps);
        logic [5:0] sx, sy;
        sx = 6'(($urandom_range(0, (w - 2) / 2) * 2) + 1);
        sy = 6'(($urandom_range(0, (h - 2) / 2) * 2) + 1);
        if (sx >= w) sx = 1;
        if (sy >= h) sy = 1;
        send_item(1'b0, sx, sy, 2'($urandom));
        for (int i = 0; i < steps; i++)
        begin
            if ($urandom_range(0, 30) == 0)
                send_item(1'($urandom), 6'($urandom), 6'($urandom), 2'($urandom));
            else
                send_item(1'b1, 6'($urandom), 6'($urandom), 2'($urandom));
        end
    endtask

    initial
    begin
        int unsigned w, h;
        int sent;
        int steps;
        calm = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_idx = REG_WIDTH;
        cfg_wdata = '0;
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle steps, bad starts, edges of the default grid
        send_item(1'b1, 6'd0, 6'd0, 2'd3);
        send_item(1'b0, 6'd2, 6'd1, 2'd0);
        send_item(1'b0, 6'd1, 6'd2, 2'd0);
        send_item(1'b0, 6'd63, 6'd1, 2'd0);
        send_item(1'b0, 6'd1, 6'd63, 2'd0);
        send_item(1'b0, 6'd61, 6'd61, 2'd0);
        for (int i = 0; i < 4; i++)
            send_item(1'b1, 6'h3f, 6'h3f, 2'(i));
        drain();

        // smallest grid: start, a pop of the start cell, finish, idle
        set_side(REG_WIDTH, 7'd3);
        set_side(REG_HEIGHT, 7'd3);
        send_item(1'b0, 6'd1, 6'd1, 2'd0);
        for (int i = 0; i < 4; i++)
            send_item(1'b1, 6'd0, 6'd0, 2'(i));
        drain();

        // clamping of out-of-range sizes
        set_side(REG_WIDTH, 7'd0);
        set_side(REG_HEIGHT, 7'd127);
        send_item(1'b0, 6'd1, 6'd63, 2'd1);
        send_item(1'b0, 6'd1, 6'd61, 2'd1);
        for (int i = 0; i < 6; i++)
            send_item(1'b1, 6'd0, 6'd0, 2'(i));
        drain();

        // random walks on mostly small grids; a few run to the finish
        sent = 0;
        while (sent < 600)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                w = $urandom_range(3, 64);
                h = $urandom_range(3, 64);
            end
            else
            begin
                w = $urandom_range(3, 11);
                h = $urandom_range(3, 11);
            end
            set_side(REG_WIDTH, 7'(w));
            set_side(REG_HEIGHT, 7'(h));
            if (sent > 480)
                calm = 1'b1;
            steps = $urandom_range(5, 60);
            run_walk(w, h, steps);
            sent += steps + 1;
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("** dfs_maze_carver: PASSED **");
        else
            $display("** dfs_maze_carver: FAILED **");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("** dfs_maze_carver: FAILED **");
        $finish;
    end

endmodule

[dfs_maze_carver.f]
hdl/dfsmc_pkg.sv
hdl/dfs_maze_carver.sv
test/dfs_maze_carver_checker.sv
test/dfs_maze_carver_tb.sv
